// ===== src/uup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform upload unpacker package
// Shared types and constants for the uniform upload unpacker.
// ----------------------------------------------------------------------------
package uup_pkg;

    localparam int unsigned NUM_VECTORS_DEF = 96;
    localparam int unsigned IDX_W           = 7;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned VAL24_W         = 24;

    // Request kinds carried in the input tuser
    localparam logic REQ_INDEX = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Word phase within one vector
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // Component mask codes
    localparam logic [3:0] MASK_NONE = 4'b0000;
    localparam logic [3:0] MASK_X    = 4'b0001;
    localparam logic [3:0] MASK_Y    = 4'b0010;
    localparam logic [3:0] MASK_Z    = 4'b0100;
    localparam logic [3:0] MASK_W    = 4'b1000;

    // One accepted input item
    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] data_word;
        logic [IDX_W-1:0]  start_index;
        logic              start_f32_mode;
    } uup_item_t;

    // One result item
    typedef struct packed {
        logic              write_valid;
        logic [IDX_W-1:0]  vector_index;
        logic [3:0]        component_mask;
        logic              is_f32;
        logic [WORD_W-1:0] comp_x;
        logic [WORD_W-1:0] comp_y;
        logic [WORD_W-1:0] comp_z;
        logic [WORD_W-1:0] comp_w;
    } uup_result_t;

endpackage

// ===== src/uup_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform upload unpacker input stage
// Registers one input transaction and hands it to the unpack core.
// ----------------------------------------------------------------------------
module uup_in_stage
    import uup_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  uup_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output uup_item_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    uup_item_t item_reg;

    // Accept when empty or when the held transaction moves on this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload unless a new transaction is taken
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/uup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform upload unpacker core
// Tracks index, phase, mode and carry bits, and builds the component write.
// ----------------------------------------------------------------------------
module uup_core
    import uup_pkg::*;
#(
    parameter int unsigned NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  uup_item_t   in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output uup_result_t out_result
);

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(NUM_VECTORS);

    logic [IDX_W-1:0]   cur_index_reg,  cur_index_next;
    logic [1:0]         word_phase_reg, word_phase_next;
    logic [VAL24_W-1:0] carry_bits_reg, carry_bits_next;
    logic               f32_mode_reg,   f32_mode_next;
    logic               valid_reg,      valid_next;
    uup_result_t        result_reg,     result_next;
    logic               take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Decode one transaction against the current state
    always_comb begin
        cur_index_next  = cur_index_reg;
        word_phase_next = word_phase_reg;
        carry_bits_next = carry_bits_reg;
        f32_mode_next   = f32_mode_reg;
        result_next     = '0;

        if (in_item.req_type == REQ_INDEX) begin
            cur_index_next = in_item.start_index;
            f32_mode_next  = in_item.start_f32_mode;
        end else if (cur_index_reg < LAST_INDEX) begin
            if (f32_mode_reg) begin
                // Full words land on w, z, y, x in turn
                result_next.write_valid  = 1'b1;
                result_next.vector_index = cur_index_reg;
                result_next.is_f32       = 1'b1;
                word_phase_next          = word_phase_reg + 2'd1;
                case (word_phase_reg)
                    PHASE_0: begin
                        result_next.component_mask = MASK_W;
                        result_next.comp_w         = in_item.data_word;
                    end
                    PHASE_1: begin
                        result_next.component_mask = MASK_Z;
                        result_next.comp_z         = in_item.data_word;
                    end
                    PHASE_2: begin
                        result_next.component_mask = MASK_Y;
                        result_next.comp_y         = in_item.data_word;
                    end
                    default: begin
                        result_next.component_mask = MASK_X;
                        result_next.comp_x         = in_item.data_word;
                        cur_index_next             = cur_index_reg + 1'b1;
                    end
                endcase
            end else begin
                // Repack three words into four 24-bit values
                case (word_phase_reg)
                    PHASE_0: begin
                        result_next.write_valid    = 1'b1;
                        result_next.vector_index   = cur_index_reg;
                        result_next.component_mask = MASK_W;
                        result_next.comp_w         = {8'h00, in_item.data_word[31:8]};
                        carry_bits_next            = {in_item.data_word[7:0], 16'h0000};
                        word_phase_next            = PHASE_1;
                    end
                    PHASE_1: begin
                        result_next.write_valid    = 1'b1;
                        result_next.vector_index   = cur_index_reg;
                        result_next.component_mask = MASK_Z;
                        result_next.comp_z         = {8'h00,
                            {8'h00, in_item.data_word[31:16]} | carry_bits_reg};
                        carry_bits_next            = {in_item.data_word[15:0], 8'h00};
                        word_phase_next            = PHASE_2;
                    end
                    PHASE_2: begin
                        result_next.write_valid    = 1'b1;
                        result_next.vector_index   = cur_index_reg;
                        result_next.component_mask = MASK_X | MASK_Y;
                        result_next.comp_y         = {8'h00,
                            {16'h0000, in_item.data_word[31:24]} | carry_bits_reg};
                        result_next.comp_x         = {8'h00, in_item.data_word[23:0]};
                        word_phase_next            = PHASE_0;
                        cur_index_next             = cur_index_reg + 1'b1;
                    end
                    default: begin
                        // Phase three after a mode change: drop the word
                        result_next.component_mask = MASK_NONE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_index_reg  <= '0;
            word_phase_reg <= PHASE_0;
            carry_bits_reg <= '0;
            f32_mode_reg   <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                cur_index_reg  <= cur_index_next;
                word_phase_reg <= word_phase_next;
                carry_bits_reg <= carry_bits_next;
                f32_mode_reg   <= f32_mode_next;
            end
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/uniform_upload_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform upload unpacker
// An input transaction passes the input register and then the result register on its way to the result.
// Throughput: one transaction per cycle while the master side accepts results, set by the single-pass unpack logic.
// Each input transaction yields exactly one result transaction.
// Reset (aresetn low, synchronous): index, phase, carry and mode clear to zero,
// both stages empty.
// ----------------------------------------------------------------------------
module uniform_upload_unpacker
    import uup_pkg::*;
#(
    parameter int unsigned NUM_VECTORS = NUM_VECTORS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: data_word[31:0], start_index[38:32], start_f32_mode[39]
    input  logic [39:0]  s_axis_tdata,
    // tuser: req_type[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: vector_index[6:0], component_mask[10:7], comp_x[42:11],
    //        comp_y[74:43], comp_z[106:75], comp_w[138:107], zero pad[143:139]
    output logic [143:0] m_axis_tdata,
    // tuser: write_valid[0], is_f32[1]
    output logic [1:0]   m_axis_tuser
);

    uup_item_t   s_item;
    uup_item_t   core_item;
    logic        core_valid;
    logic        core_ready;
    uup_result_t result;

    assign s_item.req_type       = s_axis_tuser;
    assign s_item.data_word      = s_axis_tdata[31:0];
    assign s_item.start_index    = s_axis_tdata[38:32];
    assign s_item.start_f32_mode = s_axis_tdata[39];

    uup_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    uup_core #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (core_valid),
        .in_ready   (core_ready),
        .in_item    (core_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result onto the master side
    assign m_axis_tdata = {5'b00000, result.comp_w, result.comp_z, result.comp_y,
                           result.comp_x, result.component_mask, result.vector_index};
    assign m_axis_tuser = {result.is_f32, result.write_valid};

endmodule

// ===== tb/uniform_upload_unpacker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform upload unpacker testbench
// Drives index and data transactions into the unpacker and predicts each
// component write from a behavioral copy of the index, phase, carry and mode
// state. A directed table covers reset state, both packing modes, extreme
// words, out-of-range indexes and the stray phase after a mode change. A
// random part follows with well-formed vector runs, mid-vector mode flips and
// noise. Both stream sides idle at random; one long receiver stall and two
// sender drain pauses are included.
// ----------------------------------------------------------------------------
module uniform_upload_unpacker_tb;
    import uup_pkg::*;

    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_ITEMS = 730;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AT      = 200;

    localparam uup_result_t NO_WRITE = '0;

    typedef struct {
        uup_item_t   item;
        bit          typed;
        uup_result_t want;
    } upload_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: data_word[31:0], start_index[38:32], start_f32_mode[39]
    logic [39:0]  s_axis_tdata = '0;
    // tuser: req_type[0]
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: vector_index[6:0], component_mask[10:7], comp_x[42:11],
    //        comp_y[74:43], comp_z[106:75], comp_w[138:107], zero pad[143:139]
    logic [143:0] m_axis_tdata;
    // tuser: write_valid[0], is_f32[1]
    logic [1:0]   m_axis_tuser;

    // Shadow of the unpacker state
    logic [IDX_W-1:0]   vec_idx = '0;
    logic [1:0]         phase = PHASE_0;
    logic [VAL24_W-1:0] carry24 = '0;
    logic               f32_on = 1'b0;

    uup_result_t pending_writes[$];
    upload_row_t dir_rows[DIR_ROWS];

    int err_cnt = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_index_items = 0;
    int n_f32_writes = 0;
    int n_f24_writes = 0;
    int n_dropped = 0;

    uniform_upload_unpacker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    // Advance the shadow state by one transaction and return the write it causes
    function automatic uup_result_t unpack_uniform_word(uup_item_t it);
        uup_result_t r;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0] w;
        r = NO_WRITE;
        wr_idx = vec_idx;
        w = it.data_word;
        if (it.req_type == REQ_INDEX) begin
            vec_idx = it.start_index;
            f32_on = it.start_f32_mode;
        end else if (vec_idx < NUM_VECTORS_DEF) begin
            if (f32_on) begin
                r.write_valid = 1'b1;
                case (phase)
                    PHASE_0: begin r.comp_w = w; r.component_mask = MASK_W; end
                    PHASE_1: begin r.comp_z = w; r.component_mask = MASK_Z; end
                    PHASE_2: begin r.comp_y = w; r.component_mask = MASK_Y; end
                    default: begin r.comp_x = w; r.component_mask = MASK_X; end
                endcase
                if (phase == PHASE_3) begin
                    phase = PHASE_0;
                    vec_idx = vec_idx + 1'b1;
                end else begin
                    phase = phase + 2'd1;
                end
            end else begin
                // 24-bit packing: three words carry four values, w first
                case (phase)
                    PHASE_0: begin
                        r.write_valid = 1'b1;
                        r.comp_w = {8'h00, w[31:8]};
                        r.component_mask = MASK_W;
                        carry24 = {w[7:0], 16'h0000};
                        phase = PHASE_1;
                    end
                    PHASE_1: begin
                        r.write_valid = 1'b1;
                        r.comp_z = {8'h00, carry24 | {8'h00, w[31:16]}};
                        r.component_mask = MASK_Z;
                        carry24 = {w[15:0], 8'h00};
                        phase = PHASE_2;
                    end
                    PHASE_2: begin
                        r.write_valid = 1'b1;
                        r.comp_y = {8'h00, carry24 | {16'h0000, w[31:24]}};
                        r.comp_x = {8'h00, w[23:0]};
                        r.component_mask = MASK_X | MASK_Y;
                        phase = PHASE_0;
                        vec_idx = vec_idx + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (r.write_valid) begin
            r.vector_index = wr_idx;
            r.is_f32 = f32_on;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Index transaction; the data word rides along and is ignored
    function automatic uup_item_t index_item(logic [IDX_W-1:0] idx, logic f32);
        uup_item_t it;
        it.req_type = REQ_INDEX;
        it.data_word = $urandom;
        it.start_index = idx;
        it.start_f32_mode = f32;
        return it;
    endfunction

    // Data transaction; the index fields carry junk that must be ignored
    function automatic uup_item_t data_item(logic [31:0] w);
        uup_item_t it;
        it.req_type = REQ_DATA;
        it.data_word = w;
        it.start_index = IDX_W'($urandom_range(0, 127));
        it.start_f32_mode = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic upload_row_t row_index(logic [IDX_W-1:0] idx, logic f32);
        upload_row_t row;
        row.item = '{req_type: REQ_INDEX, data_word: 32'hFFFF_FFFF,
                     start_index: idx, start_f32_mode: f32};
        row.typed = 1'b1;
        row.want = NO_WRITE;
        return row;
    endfunction

    function automatic upload_row_t row_word(logic [31:0] w, bit typed, uup_result_t want);
        upload_row_t row;
        row.item = '{req_type: REQ_DATA, data_word: w,
                     start_index: 7'h7F, start_f32_mode: 1'b1};
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic uup_result_t wrote(logic [IDX_W-1:0] idx, logic [3:0] mask,
                                          logic f32, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [31:0] w);
        uup_result_t r;
        r.write_valid = 1'b1;
        r.vector_index = idx;
        r.component_mask = mask;
        r.is_f32 = f32;
        r.comp_x = x;
        r.comp_y = y;
        r.comp_z = z;
        r.comp_w = w;
        return r;
    endfunction

    // Offer one transaction after a random gap and record its expected write
    task automatic send_item(uup_item_t it, bit typed, uup_result_t want);
        int gap;
        uup_result_t pred;
        gap = ((n_sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 3);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.start_f32_mode, it.start_index, it.data_word};
        s_axis_tuser <= it.req_type;
        do @(posedge aclk); while (!s_axis_tready);
        pred = unpack_uniform_word(it);
        pending_writes.push_back(typed ? want : pred);
        n_sent++;
        if (it.req_type == REQ_INDEX) begin
            n_index_items++;
        end else if (!pred.write_valid) begin
            n_dropped++;
        end else begin
            if (pred.is_f32) n_f32_writes++;
            else n_f24_writes++;
        end
    endtask

    // Hold the input idle until every pending write has come back
    task automatic drain_pending();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Compare one result transaction with the oldest pending write
    task automatic take_result();
        uup_result_t got;
        uup_result_t want;
        got.write_valid = m_axis_tuser[0];
        got.is_f32 = m_axis_tuser[1];
        got.vector_index = m_axis_tdata[6:0];
        got.component_mask = m_axis_tdata[10:7];
        got.comp_x = m_axis_tdata[42:11];
        got.comp_y = m_axis_tdata[74:43];
        got.comp_z = m_axis_tdata[106:75];
        got.comp_w = m_axis_tdata[138:107];
        n_results++;
        if (pending_writes.size() == 0) begin
            $error("result transaction with no write pending");
            err_cnt++;
        end else begin
            want = pending_writes.pop_front();
            check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            check_field("vector_index", 32'(want.vector_index), 32'(got.vector_index));
            check_field("component_mask", 32'(want.component_mask),
                        32'(got.component_mask));
            check_field("is_f32", 32'(want.is_f32), 32'(got.is_f32));
            check_field("comp_x", want.comp_x, got.comp_x);
            check_field("comp_y", want.comp_y, got.comp_y);
            check_field("comp_z", want.comp_z, got.comp_z);
            check_field("comp_w", want.comp_w, got.comp_w);
            check_field("tdata pad", 32'h0, 32'(m_axis_tdata[143:139]));
        end
    endtask

    // Result side: random ready gaps, one long hold-off to back up the block
    initial begin : result_sink
        int gap;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if (n_results == HOLD_AT) gap = LONG_HOLD;
            else if ((n_results / 80) % 3 == 1) gap = 0;
            else gap = $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            take_result();
            @(negedge aclk);
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("uniform_upload_unpacker_tb: errors");
        $finish;
    end

    initial begin : main_seq
        int seq_kind;
        int run_len;
        bit paused;
        logic f32;
        logic [IDX_W-1:0] idx;
        uup_item_t it;

        // Directed table: reset state, both modes, extremes and corner phases
        dir_rows = '{
            row_word(32'hAABB_CCDD, 1'b1, wrote(7'd0, MASK_W, 1'b0, 0, 0, 0, 32'h00AA_BBCC)),
            row_word(32'h1122_3344, 1'b1, wrote(7'd0, MASK_Z, 1'b0, 0, 0, 32'h00DD_1122, 0)),
            row_word(32'h5566_7788, 1'b1, wrote(7'd0, MASK_X | MASK_Y, 1'b0,
                                                32'h0066_7788, 32'h0033_4455, 0, 0)),
            row_index(7'd5, 1'b1),
            row_word(32'hFFFF_FFFF, 1'b1, wrote(7'd5, MASK_W, 1'b1, 0, 0, 0, 32'hFFFF_FFFF)),
            row_word(32'h0000_0000, 1'b1, wrote(7'd5, MASK_Z, 1'b1, 0, 0, 0, 0)),
            row_word(32'h8000_0001, 1'b1, wrote(7'd5, MASK_Y, 1'b1, 0, 32'h8000_0001, 0, 0)),
            row_word(32'h7FFF_FFFE, 1'b1, wrote(7'd5, MASK_X, 1'b1, 32'h7FFF_FFFE, 0, 0, 0)),
            row_index(7'd95, 1'b1),
            row_word(32'h1234_5678, 1'b0, NO_WRITE),
            // switch to packed mode in the middle of the last vector
            row_index(7'd95, 1'b0),
            row_word(32'hFFFF_FFFF, 1'b0, NO_WRITE),
            row_word(32'h0000_0000, 1'b0, NO_WRITE),
            // index has run past the last vector
            row_word(32'hDEAD_BEEF, 1'b1, NO_WRITE),
            row_index(7'd127, 1'b1),
            row_word(32'hFFFF_FFFF, 1'b1, NO_WRITE),
            row_index(7'd10, 1'b1),
            row_word(32'h0F0F_0F0F, 1'b0, NO_WRITE),
            row_word(32'hF0F0_F0F0, 1'b0, NO_WRITE),
            row_word(32'h3C3C_3C3C, 1'b0, NO_WRITE),
            // packed word in the fourth phase writes nothing
            row_index(7'd10, 1'b0),
            row_word(32'hA5A5_A5A5, 1'b1, NO_WRITE),
            row_index(7'd10, 1'b1),
            row_word(32'h5A5A_5A5A, 1'b0, NO_WRITE)
        };

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_pending();

        // Random part: mostly whole vector runs, some flips and noise
        paused = 1'b0;
        while (n_sent < DIR_ROWS + RANDOM_ITEMS) begin
            seq_kind = $urandom_range(0, 9);
            if (seq_kind <= 6) begin
                f32 = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0: idx = IDX_W'($urandom_range(NUM_VECTORS_DEF, 127));
                    1: idx = IDX_W'($urandom_range(NUM_VECTORS_DEF - 8, NUM_VECTORS_DEF - 1));
                    default: idx = IDX_W'($urandom_range(0, NUM_VECTORS_DEF - 1));
                endcase
                send_item(index_item(idx, f32), 1'b0, NO_WRITE);
                if ($urandom_range(0, 5) == 0) run_len = $urandom_range(1, 10);
                else run_len = (f32 ? 4 : 3) * $urandom_range(1, 3);
                for (int k = 0; k < run_len; k++) begin
                    send_item(data_item(rand_word()), 1'b0, NO_WRITE);
                end
            end else if (seq_kind == 7) begin
                // flip the mode without touching the index or phase
                send_item(index_item(vec_idx, ~f32_on), 1'b0, NO_WRITE);
                send_item(data_item(rand_word()), 1'b0, NO_WRITE);
            end else begin
                it.req_type = 1'($urandom_range(0, 1));
                it.data_word = rand_word();
                it.start_index = IDX_W'($urandom_range(0, 127));
                it.start_f32_mode = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, NO_WRITE);
            end
            if (!paused && n_sent >= DIR_ROWS + RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_pending();
            end
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d transactions: %0d index, %0d 32-bit writes, %0d 24-bit writes,",
                 n_sent, n_index_items, n_f32_writes, n_f24_writes);
        $display("%0d dropped data words; %0d results checked, %0d mismatches",
                 n_dropped, n_results, err_cnt);
        if (err_cnt == 0) begin
            $display("uniform_upload_unpacker_tb: clean");
        end else begin
            $display("uniform_upload_unpacker_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/uup_pkg.sv
src/uup_in_stage.sv
src/uup_core.sv
src/uniform_upload_unpacker.sv
tb/uniform_upload_unpacker_tb.sv
